/* rtl/event_slice_accumulator_macros.svh */
// ----------------------------------------------------------------------------
// event slice accumulator assertion macros
// shared concurrent assertion forms, clocked on aclk, off while in reset
// ----------------------------------------------------------------------------
`ifndef EVENT_SLICE_ACCUMULATOR_MACROS_SVH
`define EVENT_SLICE_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define ESA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("esa assertion failed");

// invariant checked every cycle out of reset
`define ESA_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) 1'b1 |-> (cond)) \
        else $error("esa assertion failed");

`endif

/* rtl/esa_pkg.sv */
// ----------------------------------------------------------------------------
// esa_pkg
// types and constants of the event slice accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esa_pkg;

    localparam int SENSOR_WIDTH     = 240;
    localparam int SENSOR_HEIGHT    = 180;
    localparam int SLICE_COUNT      = 3;
    localparam int PIXELS_PER_SLICE = SENSOR_WIDTH * SENSOR_HEIGHT;
    localparam int STORE_DEPTH      = SLICE_COUNT * PIXELS_PER_SLICE;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);
    localparam int SLICE_W          = $clog2(SLICE_COUNT);
    localparam int SEL_W            = SLICE_W + 2;
    localparam int CMP_W            = 12;

    // fixed field widths
    localparam int KIND_W      = 2;
    localparam int X_W         = 8;
    localparam int Y_W         = 8;
    localparam int AGE_W       = 2;
    localparam int COUNT_W     = 8;
    localparam int CUR_W       = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_EVENT  = 2'd0,
        KIND_ROTATE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic calc_addr;
        logic mem_read;
        logic ev_write;
        logic out_load;
        logic rotate;
        logic clear_all;
        logic sweep_step;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  sweep_last;
        logic  out_free;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/esa_ctrl.sv */
// ----------------------------------------------------------------------------
// esa_ctrl
// sequencer for item decode, read-modify-write and clearing sweeps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esa_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire esa_pkg::sts_t sts,
    output esa_pkg::cmd_t      cmd
);
    import esa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP: begin
                if (sts.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_ADDR;
            end
            ST_ADDR: begin
                case (sts.kind)
                    KIND_ROTATE, KIND_CLEAR: state_next = ST_SWEEP;
                    default:                 state_next = ST_READ;
                endcase
            end
            ST_READ: begin
                state_next = (sts.kind == KIND_READ) ? ST_OUT : ST_WRITE;
            end
            ST_WRITE: begin
                state_next = ST_IDLE;
            end
            ST_OUT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_SWEEP: cmd.sweep_step = 1'b1;
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_ADDR: begin
                cmd.calc_addr = 1'b1;
                cmd.rotate    = (sts.kind == KIND_ROTATE);
                cmd.clear_all = (sts.kind == KIND_CLEAR);
            end
            ST_READ:  cmd.mem_read = 1'b1;
            ST_WRITE: cmd.ev_write = 1'b1;
            ST_OUT:   cmd.out_load = sts.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/esa_datapath.sv */
// ----------------------------------------------------------------------------
// esa_datapath
// slice store, address generation, sweep counter and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esa_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [esa_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [esa_pkg::KIND_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [esa_pkg::M_TDATA_W-1:0]       m_tdata,
    input  wire esa_pkg::cmd_t                  cmd,
    output esa_pkg::sts_t                       sts
);
    import esa_pkg::*;

    // captured item
    kind_t            kind_reg;
    logic [X_W-1:0]   x_reg;
    logic [Y_W-1:0]   y_reg;
    logic             pol_reg;
    logic [AGE_W-1:0] age_reg;

    logic [SLICE_W-1:0] cur_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               inside_reg;
    logic [COUNT_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]  sweep_addr_reg;
    logic [ADDR_W-1:0]  sweep_end_reg;
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [CUR_W-1:0]   out_cur_reg;

    logic [COUNT_W-1:0] mem [STORE_DEPTH];

    logic               on_sensor;
    logic [SEL_W-1:0]   age_ext;
    logic [SEL_W-1:0]   sel_sum;
    logic [SLICE_W-1:0] slice_sel;
    logic [ADDR_W-1:0]  addr_calc;
    logic [SLICE_W-1:0] cur_inc;
    logic [ADDR_W-1:0]  rot_base;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;

    always_comb begin
        on_sensor = (CMP_W'(x_reg) < CMP_W'(SENSOR_WIDTH))
                 && (CMP_W'(y_reg) < CMP_W'(SENSOR_HEIGHT));

        // slice picked by age for reads, older slices sit behind the current one
        age_ext = SEL_W'(age_reg);
        if (age_ext > SEL_W'(SLICE_COUNT - 1)) age_ext = SEL_W'(SLICE_COUNT - 1);
        sel_sum = SEL_W'(cur_reg) + SEL_W'(SLICE_COUNT) - age_ext;
        if (sel_sum >= SEL_W'(SLICE_COUNT)) sel_sum = sel_sum - SEL_W'(SLICE_COUNT);
        slice_sel = (kind_reg == KIND_READ) ? SLICE_W'(sel_sum) : cur_reg;

        addr_calc = ADDR_W'(slice_sel) * ADDR_W'(PIXELS_PER_SLICE)
                  + ADDR_W'(y_reg) * ADDR_W'(SENSOR_WIDTH)
                  + ADDR_W'(x_reg);

        cur_inc  = (cur_reg == SLICE_W'(SLICE_COUNT - 1)) ? '0 : cur_reg + 1'b1;
        rot_base = ADDR_W'(cur_inc) * ADDR_W'(PIXELS_PER_SLICE);

        mem_we    = cmd.sweep_step || (cmd.ev_write && pol_reg && inside_reg);
        mem_waddr = cmd.sweep_step ? sweep_addr_reg : addr_reg;
        mem_wdata = cmd.sweep_step ? '0 : rdata_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= kind_t'(s_tuser);
            x_reg    <= s_tdata[0 +: X_W];
            y_reg    <= s_tdata[X_W +: Y_W];
            pol_reg  <= s_tdata[X_W + Y_W];
            age_reg  <= s_tdata[X_W + Y_W + 1 +: AGE_W];
        end
        if (cmd.calc_addr) begin
            addr_reg   <= addr_calc;
            inside_reg <= on_sensor;
        end
        if (cmd.out_load) begin
            out_count_reg <= inside_reg ? rdata_reg : '0;
            out_cur_reg   <= CUR_W'(cur_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (cmd.mem_read) rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= ADDR_W'(STORE_DEPTH - 1);
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.rotate) begin
                cur_reg        <= cur_inc;
                sweep_addr_reg <= rot_base;
                sweep_end_reg  <= rot_base + ADDR_W'(PIXELS_PER_SLICE - 1);
            end else if (cmd.clear_all) begin
                sweep_addr_reg <= '0;
                sweep_end_reg  <= ADDR_W'(STORE_DEPTH - 1);
            end else if (cmd.sweep_step) begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.kind       = kind_reg;
    assign sts.sweep_last = (sweep_addr_reg == sweep_end_reg);
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - COUNT_W - CUR_W){1'b0}}, out_cur_reg, out_count_reg};

endmodule

`default_nettype wire

/* rtl/event_slice_accumulator.sv */
// ----------------------------------------------------------------------------
// event_slice_accumulator
// three rotating slices of 8-bit per-pixel event counts for an event sensor
// ----------------------------------------------------------------------------
//  channel | dir | tdata (lsb first)                        | tuser
//  s_      | in  | pixel_x 8, pixel_y 8, polarity 1, age 2  | kind 2
//  m_      | out | pixel_count 8, current_slice 2           | -
//
//  an event steps through accept, address, store read, store write
//  a read steps through accept, address, store read and a wait for the result register to free up
//  rotate clears one slice with a sweep of its 43200 entries, clear all the 129600 entries of the store,
//  one store entry per cycle through the single write port
//  after reset the whole store is swept to zero, s_tready low
//  a stalled result holds in m_ while the next non-read word is still taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "event_slice_accumulator_macros.svh"

module event_slice_accumulator (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // pixel_x [7:0], pixel_y [15:8], polarity [16], slice_age [18:17]
    input  wire logic [esa_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind [1:0]
    input  wire logic [esa_pkg::KIND_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // pixel_count [7:0], current_slice [9:8]
    output logic [esa_pkg::M_TDATA_W-1:0]       m_tdata
);
    import esa_pkg::*;

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: decode, read-modify-write steps, sweeps
    esa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // store, slice index, address math and result register
    esa_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

    // a pending result is never overwritten
    `ESA_ASSERT_IMPL(a_no_result_overwrite, cmd.out_load, sts.out_free)
    // the sequencer drives at most one store or result step per cycle
    `ESA_ASSERT_ALWAYS(a_one_step, $onehot0({cmd.mem_read, cmd.ev_write, cmd.out_load, cmd.sweep_step}))
    // the reported slice index stays within the slice count
    `ESA_ASSERT_IMPL(a_slice_range, m_tvalid, m_tdata[COUNT_W +: CUR_W] < CUR_W'(SLICE_COUNT))

endmodule

`default_nettype wire
